// File: rtl/core/sce_pkg.sv
// Shared constants, instruction codes and request/result types for the stack calculator.
`default_nettype none

package sce_pkg;

    // Sizes of the storage and the datapath.
    localparam int STACK_DEPTH = 16;
    localparam int NUM_VARS    = 16;
    localparam int DATA_WIDTH  = 32;

    // Fixed field widths of the request and result items.
    localparam int FUNC_W    = 4;
    localparam int OPERAND_W = 32;
    localparam int VAR_W     = 4;
    localparam int ROUTINE_W = 8;
    localparam int TOP_W     = 32;
    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int DEPTH_W   = 5;
    localparam int VIDX_W    = $clog2(NUM_VARS);

    // Instruction codes.
    localparam logic [FUNC_W-1:0] FUNC_PUSH  = 4'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 4'd1;
    localparam logic [FUNC_W-1:0] FUNC_SUB   = 4'd2;
    localparam logic [FUNC_W-1:0] FUNC_MUL   = 4'd3;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 4'd4;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 4'd5;
    localparam logic [FUNC_W-1:0] FUNC_JUMP  = 4'd6;
    localparam logic [FUNC_W-1:0] FUNC_JUMPZ = 4'd7;
    localparam logic [FUNC_W-1:0] FUNC_HSET  = 4'd8;

    // One instruction request.
    typedef struct packed {
        logic [FUNC_W-1:0]           func;
        logic signed [OPERAND_W-1:0] operand_value;
        logic [VAR_W-1:0]            var_index;
        logic [ROUTINE_W-1:0]        routine_id;
    } t_req;

    // One result item.
    typedef struct packed {
        logic signed [TOP_W-1:0] top_value;
        logic [DEPTH_W-1:0]      stack_depth;
        logic                    jump_taken;
        logic [ROUTINE_W-1:0]    jump_target;
        logic                    overflow;
    } t_rsp;

endpackage

`default_nettype wire

// File: rtl/core/sce_req_if.sv
// Valid/ready channel that carries instruction requests.
`default_nettype none

interface sce_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [sce_pkg::FUNC_W-1:0]           func;
    logic signed [sce_pkg::OPERAND_W-1:0] operand_value;
    logic [sce_pkg::VAR_W-1:0]            var_index;
    logic [sce_pkg::ROUTINE_W-1:0]        routine_id;

    modport source (
        output valid, func, operand_value, var_index, routine_id,
        input  ready
    );
    modport sink (
        input  valid, func, operand_value, var_index, routine_id,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/sce_rsp_if.sv
// Valid/ready channel that carries result items.
`default_nettype none

interface sce_rsp_if;
    logic                             valid;
    logic                             ready;
    logic signed [sce_pkg::TOP_W-1:0] top_value;
    logic [sce_pkg::DEPTH_W-1:0]      stack_depth;
    logic                             jump_taken;
    logic [sce_pkg::ROUTINE_W-1:0]    jump_target;
    logic                             overflow;

    modport source (
        output valid, top_value, stack_depth, jump_taken, jump_target, overflow,
        input  ready
    );
    modport sink (
        input  valid, top_value, stack_depth, jump_taken, jump_target, overflow,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/stack_calculator_executor_top.sv
// Top level of the stack calculator executor: request register, execute stage, result register.
//
//   channel  | dir | modport | payload
//   ---------+-----+---------+--------------------------------------------------------
//   i_req    | in  | sink    | func, operand_value, var_index, routine_id
//   o_rsp    | out | source  | top_value, stack_depth, jump_taken, jump_target, overflow
//
// One request per cycle while o_rsp.ready is high; both registers lie on the result path.
// The request register feeds the execute logic, whose single 32x32 multiply sets the path.
// Reset clears the stack depth, the variable valid bits and both valid flags; no sweep is needed.
// A stalled result holds in the result register while one more request waits in the request
// register; i_req.ready drops only when both are full and o_rsp.ready is low.
`default_nettype none

module stack_calculator_executor_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sce_req_if.sink   i_req,
    sce_rsp_if.source o_rsp
);

    sce_pkg::t_req r_req;
    logic          r_req_valid;
    sce_pkg::t_rsp r_rsp;
    logic          r_rsp_valid;
    sce_pkg::t_rsp exec_rsp;
    logic          rsp_load;
    logic          exec_en;
    logic          req_take;

    // Pipeline advance: the result register frees up when empty or being drained.
    assign rsp_load    = !r_rsp_valid || o_rsp.ready;
    assign exec_en     = r_req_valid && rsp_load;
    assign i_req.ready = !r_req_valid || rsp_load;
    assign req_take    = i_req.valid && i_req.ready;

    // Request register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_req_valid <= i_req.valid;
        end
    end

    // Request register payload.
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_req.func          <= i_req.func;
            r_req.operand_value <= i_req.operand_value;
            r_req.var_index     <= i_req.var_index;
            r_req.routine_id    <= i_req.routine_id;
        end
    end

    sce_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (exec_en),
        .i_req   (r_req),
        .o_rsp   (exec_rsp)
    );

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (rsp_load) begin
            r_rsp_valid <= r_req_valid;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (exec_en) begin
            r_rsp <= exec_rsp;
        end
    end

    // Output channel drive.
    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.top_value   = r_rsp.top_value;
    assign o_rsp.stack_depth = r_rsp.stack_depth;
    assign o_rsp.jump_taken  = r_rsp.jump_taken;
    assign o_rsp.jump_target = r_rsp.jump_target;
    assign o_rsp.overflow    = r_rsp.overflow;

    // Every executed request lands in the result register.
    a_exec_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_en |=> r_rsp_valid)
        else $error("executed request did not produce a result");

    // A waiting request is never executed while the result register is stuck.
    a_no_exec_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && !o_rsp.ready) |-> !exec_en)
        else $error("request executed over a stalled result");

    // A request accepted while none waits is held for execution.
    a_take_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take |=> r_req_valid)
        else $error("accepted request was lost");

endmodule

`default_nettype wire

// File: rtl/core/sce_exec.sv
// Operand stack, variable store and combinational instruction execute logic.
`default_nettype none

module sce_exec (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire sce_pkg::t_req i_req,
    output sce_pkg::t_rsp      o_rsp
);

    // Stack motion codes.
    localparam logic [1:0] ST_HOLD = 2'd0;
    localparam logic [1:0] ST_PUSH = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;
    localparam logic [1:0] ST_REPL = 2'd3;

    localparam int DW = sce_pkg::DATA_WIDTH;
    localparam int SD = sce_pkg::STACK_DEPTH;
    localparam int CW = sce_pkg::CNT_W;

    // Shift-register stack: entry 0 is the top of stack.
    logic [DW-1:0]            r_stk [SD];
    logic [DW-1:0]            n_stk [SD];
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic [DW-1:0]            r_var [sce_pkg::NUM_VARS];
    logic [sce_pkg::NUM_VARS-1:0] r_var_valid;

    logic [1:0]               stk_op;
    logic [DW-1:0]            stk_val;
    logic                     var_we;
    logic [DW-1:0]            var_wdata;
    logic [DW-1:0]            var_rdata;
    logic [DW-1:0]            operand_ext;
    logic [DW-1:0]            alu_res;
    logic [DW-1:0]            top_t;
    logic [DW-1:0]            second_s;
    logic [sce_pkg::VIDX_W-1:0] vidx;
    logic                     vidx_ok;
    logic                     full;
    logic                     jumped;
    logic                     ovf;

    assign top_t       = r_stk[0];
    assign second_s    = r_stk[1];
    assign operand_ext = DW'(i_req.operand_value);
    assign vidx        = i_req.var_index[sce_pkg::VIDX_W-1:0];
    assign vidx_ok     = (int'(i_req.var_index) < sce_pkg::NUM_VARS);
    assign full        = (r_count >= CW'(SD));
    assign var_rdata   = (vidx_ok && r_var_valid[vidx]) ? r_var[vidx] : '0;

    // Arithmetic on the top two entries; all results wrap.
    always_comb begin
        case (i_req.func)
            sce_pkg::FUNC_ADD: alu_res = top_t + second_s;
            sce_pkg::FUNC_SUB: alu_res = top_t - second_s;
            default:           alu_res = top_t * second_s;
        endcase
    end

    // Instruction decode into a stack motion, a variable write and flags.
    always_comb begin
        stk_op    = ST_HOLD;
        stk_val   = '0;
        var_we    = 1'b0;
        var_wdata = '0;
        jumped    = 1'b0;
        ovf       = 1'b0;
        case (i_req.func)
            sce_pkg::FUNC_PUSH: begin
                stk_val = operand_ext;
                if (full) begin
                    ovf = 1'b1;
                end else begin
                    stk_op = ST_PUSH;
                end
            end
            sce_pkg::FUNC_ADD, sce_pkg::FUNC_SUB, sce_pkg::FUNC_MUL: begin
                if (r_count >= CW'(2)) begin
                    stk_op  = ST_REPL;
                    stk_val = alu_res;
                end else if (r_count == '0) begin
                    stk_op  = ST_PUSH;
                end
            end
            sce_pkg::FUNC_WRITE: begin
                var_we = 1'b1;
                if (r_count != '0) begin
                    var_wdata = top_t;
                    stk_op    = ST_POP;
                end
            end
            sce_pkg::FUNC_READ: begin
                stk_val = var_rdata;
                if (full) begin
                    ovf = 1'b1;
                end else begin
                    stk_op = ST_PUSH;
                end
            end
            sce_pkg::FUNC_JUMP: begin
                jumped = 1'b1;
            end
            sce_pkg::FUNC_JUMPZ: begin
                if (r_count == '0) begin
                    jumped = 1'b1;
                end else begin
                    jumped = (top_t == '0);
                    stk_op = ST_POP;
                end
            end
            sce_pkg::FUNC_HSET: begin
                var_we    = 1'b1;
                var_wdata = operand_ext;
            end
            default: begin
            end
        endcase
    end

    // Next stack: entries shift or hold; entry 0 may also load a new value.
    always_comb begin
        n_count = r_count;
        for (int i = 0; i < SD; i++) begin
            n_stk[i] = r_stk[i];
        end
        case (stk_op)
            ST_PUSH: begin
                n_count  = r_count + CW'(1);
                n_stk[0] = stk_val;
                for (int i = 1; i < SD; i++) begin
                    n_stk[i] = r_stk[i-1];
                end
            end
            ST_POP: begin
                n_count = r_count - CW'(1);
                for (int i = 0; i < SD - 1; i++) begin
                    n_stk[i] = r_stk[i+1];
                end
            end
            ST_REPL: begin
                n_count  = r_count - CW'(1);
                n_stk[0] = stk_val;
                for (int i = 1; i < SD - 1; i++) begin
                    n_stk[i] = r_stk[i+1];
                end
            end
            default: begin
            end
        endcase
    end

    // Result as seen after this instruction.
    always_comb begin
        o_rsp.top_value   = (n_count != '0) ? sce_pkg::TOP_W'(n_stk[0]) : '0;
        o_rsp.stack_depth = sce_pkg::DEPTH_W'(n_count);
        o_rsp.jump_taken  = jumped;
        o_rsp.jump_target = jumped ? i_req.routine_id : '0;
        o_rsp.overflow    = ovf;
    end

    // Control state: depth and variable valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_var_valid <= '0;
        end else if (i_en) begin
            r_count <= n_count;
            if (var_we && vidx_ok) begin
                r_var_valid[vidx] <= 1'b1;
            end
        end
    end

    // Payload storage.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < SD; i++) begin
                r_stk[i] <= n_stk[i];
            end
            if (var_we && vidx_ok) begin
                r_var[vidx] <= var_wdata;
            end
        end
    end

    // The depth never passes the stack size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SD))
        else $error("stack depth above capacity");

    // The depth moves by at most one entry per instruction.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count)
                         || r_count == CW'($past(r_count) + CW'(1))
                         || r_count == CW'($past(r_count) - CW'(1))))
        else $error("stack depth changed by more than one");

    // A dropped push happens only on a full stack, and leaves it full.
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_rsp.overflow) |=> r_count == CW'(SD))
        else $error("overflow reported on a stack that was not full");

endmodule

`default_nettype wire
